// ===== rtl/ace_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_pkg: types and constants of the ARP cache engine
// Request/response payloads, controller state, control/status bundles, codes.
// ----------------------------------------------------------------------------
package ace_pkg;

   typedef struct packed {
      logic        opcode;
      logic [10:0] frame_len;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
      logic [15:0] arp_op;
      logic [47:0] sender_ha;
      logic [31:0] sender_pa;
      logic [31:0] target_pa;
      logic [31:0] query_pa;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        send_frame;
      logic [1:0]  send_op;
      logic [47:0] send_tha;
      logic [31:0] send_tpa;
      logic        send_broadcast;
      logic [47:0] resolved_ha;
   } rsp_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_HA,
      CTL_DONE
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } sts_type;

   localparam logic OPC_FRAME = 1'b0;
   localparam logic OPC_QUERY = 1'b1;

   localparam logic [2:0] STS_SHORT      = 3'd0;
   localparam logic [2:0] STS_BAD_TYPE   = 3'd1;
   localparam logic [2:0] STS_ACCEPTED   = 3'd2;
   localparam logic [2:0] STS_REPLIED    = 3'd3;
   localparam logic [2:0] STS_FOUND      = 3'd4;
   localparam logic [2:0] STS_INCOMPLETE = 3'd5;
   localparam logic [2:0] STS_ERROR      = 3'd6;

   localparam logic [1:0] ENT_FREE       = 2'd0;
   localparam logic [1:0] ENT_INCOMPLETE = 2'd1;
   localparam logic [1:0] ENT_RESOLVED   = 2'd2;

   localparam logic [1:0] SOP_NONE    = 2'd0;
   localparam logic [1:0] SOP_REQUEST = 2'd1;
   localparam logic [1:0] SOP_REPLY   = 2'd2;

   localparam logic [15:0] ARP_REQ_OP     = 16'd1;
   localparam logic [15:0] ARP_REP_OP     = 16'd2;
   localparam logic [15:0] HW_ETHER       = 16'h0001;
   localparam logic [15:0] PROTO_IPV4     = 16'h0800;
   localparam logic [7:0]  HW_LEN_ETHER   = 8'd6;
   localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
   localparam logic [10:0] MIN_FRAME      = 11'd28;

   localparam logic [1:0] CSR_LOCAL_IP   = 2'd0;
   localparam logic [1:0] CSR_LOCAL_MAC  = 2'd1;
   localparam logic [1:0] CSR_LINK_ETHER = 2'd2;
   localparam logic [1:0] CSR_IFACE      = 2'd3;

endpackage

// ===== rtl/ace_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ace_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ace_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_ctrl: request sequencer
// Steps each request through capture, cache scan, address read and commit.
// ----------------------------------------------------------------------------
module ace_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ace_pkg::sts_type sts,
   output ace_pkg::cmd_type cmd
);

   ace_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ace_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ace_pkg::CTL_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ace_pkg::CTL_SCAN;
            end
         end
         ace_pkg::CTL_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ace_pkg::CTL_HA;
            end
         end
         ace_pkg::CTL_HA: begin
            state_in = ace_pkg::CTL_DONE;
         end
         ace_pkg::CTL_DONE: begin
            cmd.commit = sts.rsp_free;
            if (sts.rsp_free) begin
               state_in = ace_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = ace_pkg::CTL_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ace_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_datapath: ARP cache storage, scan and result datapath
// Holds the config registers, entry state flops and entry RAMs, scans for
// hit / free / oldest entry, and builds the response.
// ----------------------------------------------------------------------------
module ace_datapath #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  ace_pkg::req_type req_data,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [47:0]      csr_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output ace_pkg::rsp_type rsp_data,
   input  ace_pkg::cmd_type cmd,
   output ace_pkg::sts_type sts
);

   localparam int IW = $clog2(CACHE_ENTRIES);
   localparam int CW = $clog2(CACHE_ENTRIES + 1);

   ace_pkg::req_type req_ff;
   ace_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   logic [31:0] lip_ff;
   logic [47:0] lmac_ff;
   logic        eth_ff, ifc_ff;

   logic [1:0]    ent_st_ff [CACHE_ENTRIES];
   logic [CW-1:0] cnt_ff;
   logic          cmp_vld_ff;
   logic [IW-1:0] cmp_idx_ff;
   logic [1:0]    cmp_st_ff;

   logic          hit_ff, free_ff, old_ff;
   logic          hit_in, free_in, old_in;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, old_idx_ff;
   logic [IW-1:0] hit_idx_in, free_idx_in, old_idx_in;
   logic [1:0]    hit_st_ff, hit_st_in;
   logic [31:0]   old_stamp_ff, old_stamp_in;

   logic          issue;
   logic [IW-1:0] rd_idx;
   logic [31:0]   key;
   logic [31:0]   pa_rd, stamp_rd;
   logic [47:0]   ha_rd;

   logic          is_frame, frame_ok, tgt, q_ok;
   logic          wr_en, ha_wr_en;
   logic [IW-1:0] wr_idx, slot;
   logic [1:0]    wr_st;
   logic [31:0]   wr_pa;

   assign issue  = cmd.scan && (cnt_ff < CW'(CACHE_ENTRIES));
   assign rd_idx = cnt_ff[IW-1:0];
   assign key    = (req_ff.opcode == ace_pkg::OPC_FRAME) ? req_ff.sender_pa
                                                         : req_ff.query_pa;

   ace_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_pa_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(wr_pa),
      .rd_addr(rd_idx), .rd_data(pa_rd)
   );
   ace_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_stamp_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_idx), .wr_data(req_ff.time_now),
      .rd_addr(rd_idx), .rd_data(stamp_rd)
   );
   ace_ram #(.WIDTH(48), .DEPTH(CACHE_ENTRIES)) u_ha_ram (
      .clock(clock), .wr_en(ha_wr_en), .wr_addr(wr_idx), .wr_data(req_ff.sender_ha),
      .rd_addr(hit_idx_ff), .rd_data(ha_rd)
   );

   // scan compare: first hit, first free, oldest used (ties keep lowest)
   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_st_in    = hit_st_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      old_stamp_in = old_stamp_ff;
      if (cmp_vld_ff) begin
         if (cmp_st_ff != ace_pkg::ENT_FREE) begin
            if (!hit_ff && pa_rd == key) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               hit_st_in  = cmp_st_ff;
            end
            if (!old_ff || stamp_rd < old_stamp_ff) begin
               old_in       = 1'b1;
               old_idx_in   = cmp_idx_ff;
               old_stamp_in = stamp_rd;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   // decision and response
   always_comb begin
      is_frame = req_ff.opcode == ace_pkg::OPC_FRAME;
      frame_ok = req_ff.frame_len >= ace_pkg::MIN_FRAME
                 && req_ff.hw_type == ace_pkg::HW_ETHER
                 && req_ff.hw_len == ace_pkg::HW_LEN_ETHER
                 && req_ff.proto_type == ace_pkg::PROTO_IPV4
                 && req_ff.proto_len == ace_pkg::PROTO_LEN_IPV4;
      tgt      = ifc_ff && lip_ff == req_ff.target_pa;
      q_ok     = eth_ff && ifc_ff;
      slot     = free_ff ? free_idx_ff : old_idx_ff;
      wr_idx   = hit_ff ? hit_idx_ff : slot;
      rsp_in   = '0;
      wr_en    = 1'b0;
      ha_wr_en = 1'b0;
      wr_st    = ace_pkg::ENT_RESOLVED;
      wr_pa    = key;
      if (is_frame) begin
         if (req_ff.frame_len < ace_pkg::MIN_FRAME) begin
            rsp_in.status = ace_pkg::STS_SHORT;
         end else if (!frame_ok) begin
            rsp_in.status = ace_pkg::STS_BAD_TYPE;
         end else begin
            wr_en         = cmd.commit && (hit_ff || tgt);
            ha_wr_en      = wr_en;
            rsp_in.status = ace_pkg::STS_ACCEPTED;
            if (tgt && req_ff.arp_op == ace_pkg::ARP_REQ_OP) begin
               rsp_in.status     = ace_pkg::STS_REPLIED;
               rsp_in.send_frame = 1'b1;
               rsp_in.send_op    = ace_pkg::SOP_REPLY;
               rsp_in.send_tha   = req_ff.sender_ha;
               rsp_in.send_tpa   = req_ff.sender_pa;
            end
         end
      end else if (!q_ok) begin
         rsp_in.status = ace_pkg::STS_ERROR;
      end else if (hit_ff && hit_st_ff != ace_pkg::ENT_INCOMPLETE) begin
         rsp_in.status      = ace_pkg::STS_FOUND;
         rsp_in.resolved_ha = ha_rd;
      end else begin
         wr_en                 = cmd.commit && !hit_ff;
         wr_st                 = ace_pkg::ENT_INCOMPLETE;
         rsp_in.status         = ace_pkg::STS_INCOMPLETE;
         rsp_in.send_frame     = 1'b1;
         rsp_in.send_op        = ace_pkg::SOP_REQUEST;
         rsp_in.send_tpa       = req_ff.query_pa;
         rsp_in.send_broadcast = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         old_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lip_ff       <= '0;
         lmac_ff      <= '0;
         eth_ff       <= 1'b1;
         ifc_ff       <= 1'b1;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            ent_st_ff[i] <= ace_pkg::ENT_FREE;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               ace_pkg::CSR_LOCAL_IP:   lip_ff  <= csr_data[31:0];
               ace_pkg::CSR_LOCAL_MAC:  lmac_ff <= csr_data;
               ace_pkg::CSR_LINK_ETHER: eth_ff  <= csr_data[0];
               ace_pkg::CSR_IFACE:      ifc_ff  <= csr_data[0];
               default: ;
            endcase
         end
         cmp_vld_ff <= issue;
         if (cmd.capture) begin
            cnt_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            old_ff  <= 1'b0;
         end else begin
            if (issue) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            hit_ff  <= hit_in;
            free_ff <= free_in;
            old_ff  <= old_in;
         end
         if (wr_en) begin
            ent_st_ff[wr_idx] <= wr_st;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
      cmp_idx_ff   <= rd_idx;
      cmp_st_ff    <= ent_st_ff[rd_idx];
      hit_idx_ff   <= hit_idx_in;
      hit_st_ff    <= hit_st_in;
      free_idx_ff  <= free_idx_in;
      old_idx_ff   <= old_idx_in;
      old_stamp_ff <= old_stamp_in;
   end

   assign sts.scan_done = (cnt_ff == CW'(CACHE_ENTRIES)) && !cmp_vld_ff;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CACHE_ENTRIES))
      else $error("scan counter past cache depth");

   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.scan_done)
      else $error("commit before scan finished");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ace_pkg::STS_ERROR |-> !rsp_ff.send_frame)
      else $error("error response sends a frame");

   a_found_no_send: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && rsp_in.status == ace_pkg::STS_FOUND |-> !wr_en)
      else $error("found query modifies cache");

endmodule

// ===== rtl/arp_cache_engine.sv =====
`timescale 1ns / 1ps
// Scan: one cache entry per cycle over the entry RAM read port.
// Requests: one at a time; a new request is taken only after the last response
//   is committed, so a stalled response output backs up the request channel.
// Reset: synchronous; all cache entries free, local_ip/local_mac zero,
//   link_is_ethernet and ip_iface_present set; config writes are taken always.
// ----------------------------------------------------------------------------
// arp_cache_engine: IPv4-over-Ethernet ARP engine with a fixed cache
// Handles received ARP frames and resolve queries, one response per request.
// ----------------------------------------------------------------------------
module arp_cache_engine #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ace_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ace_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [47:0]      csr_data
);

   ace_pkg::cmd_type cmd;
   ace_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   ace_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd)
   );

   ace_datapath #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .cmd(cmd), .sts(sts)
   );

endmodule

// ===== sim/arp_cache_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_engine_tb: self-checking bench for the ARP cache engine
// Drives frames and resolve queries through a shadow ARP cache and compares
// every response field; random idle on both sides plus one long response
// stall that backs up the request channel.
// ----------------------------------------------------------------------------
module arp_cache_engine_tb;

   localparam int NENT  = 32;
   localparam int REQ_W = $bits(ace_pkg::req_type);

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ace_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ace_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic [47:0]      csr_data = '0;

   arp_cache_engine #(.CACHE_ENTRIES(NENT)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow cache and interface settings
   logic [31:0] my_ip;
   logic [47:0] my_mac;
   logic        link_ether, iface_up;
   logic [1:0]  ent_state [NENT];
   logic [31:0] ent_pa    [NENT];
   logic [47:0] ent_ha    [NENT];
   logic [31:0] ent_stamp [NENT];

   ace_pkg::rsp_type pending_rsp[$];
   int      errors = 0;
   int      hold_cycles = 0;
   int      rsp_idle = 0;
   logic [31:0] clk_now = 0;
   logic [31:0] addr_pool [8];

   function automatic int lookup(logic [31:0] pa);
      for (int i = 0; i < NENT; i++)
         if (ent_state[i] != ace_pkg::ENT_FREE && ent_pa[i] == pa) return i;
      return -1;
   endfunction

   function automatic int victim_slot();
      int v;
      v = 0;
      for (int i = 0; i < NENT; i++) begin
         if (ent_state[i] == ace_pkg::ENT_FREE) return i;
         if (ent_stamp[v] > ent_stamp[i]) v = i;
      end
      return v;
   endfunction

   function automatic void resolve_entry(int i, logic [31:0] pa, logic [47:0] ha,
                                         logic [31:0] t);
      ent_state[i] = ace_pkg::ENT_RESOLVED;
      ent_pa[i]    = pa;
      ent_ha[i]    = ha;
      ent_stamp[i] = t;
   endfunction

   function automatic ace_pkg::rsp_type arp_predict(ace_pkg::req_type r);
      ace_pkg::rsp_type o;
      int      i;
      bit      merged;
      o = '0;
      if (r.opcode == ace_pkg::OPC_FRAME) begin
         if (r.frame_len < ace_pkg::MIN_FRAME) o.status = ace_pkg::STS_SHORT;
         else if (r.hw_type != ace_pkg::HW_ETHER || r.hw_len != ace_pkg::HW_LEN_ETHER ||
                  r.proto_type != ace_pkg::PROTO_IPV4 ||
                  r.proto_len != ace_pkg::PROTO_LEN_IPV4)
            o.status = ace_pkg::STS_BAD_TYPE;
         else begin
            i = lookup(r.sender_pa);
            merged = (i >= 0);
            if (merged) resolve_entry(i, r.sender_pa, r.sender_ha, r.time_now);
            o.status = ace_pkg::STS_ACCEPTED;
            if (iface_up && my_ip == r.target_pa) begin
               if (!merged)
                  resolve_entry(victim_slot(), r.sender_pa, r.sender_ha, r.time_now);
               if (r.arp_op == ace_pkg::ARP_REQ_OP) begin
                  o.status     = ace_pkg::STS_REPLIED;
                  o.send_frame = 1'b1;
                  o.send_op    = ace_pkg::SOP_REPLY;
                  o.send_tha   = r.sender_ha;
                  o.send_tpa   = r.sender_pa;
               end
            end
         end
      end else if (!link_ether || !iface_up) begin
         o.status = ace_pkg::STS_ERROR;
      end else begin
         i = lookup(r.query_pa);
         if (i < 0) begin
            i = victim_slot();
            ent_state[i] = ace_pkg::ENT_INCOMPLETE;
            ent_pa[i]    = r.query_pa;
            ent_stamp[i] = r.time_now;
         end
         if (ent_state[i] == ace_pkg::ENT_INCOMPLETE) begin
            o.status         = ace_pkg::STS_INCOMPLETE;
            o.send_frame     = 1'b1;
            o.send_op        = ace_pkg::SOP_REQUEST;
            o.send_tpa       = r.query_pa;
            o.send_broadcast = 1'b1;
         end else begin
            o.status      = ace_pkg::STS_FOUND;
            o.resolved_ha = ent_ha[i];
         end
      end
      return o;
   endfunction

   task automatic send_request(ace_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_rsp.push_back(arp_predict(r));
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ace_pkg::CSR_LOCAL_IP:   my_ip = val[31:0];
         ace_pkg::CSR_LOCAL_MAC:  my_mac = val;
         ace_pkg::CSR_LINK_ETHER: link_ether = val[0];
         default:                 iface_up = val[0];
      endcase
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (NENT + 10) @(posedge clock);
   endtask

   function automatic ace_pkg::req_type good_frame(logic [15:0] op, logic [47:0] sha,
                                                   logic [31:0] spa, logic [31:0] tpa);
      ace_pkg::req_type r;
      r = '0;
      r.opcode = ace_pkg::OPC_FRAME;
      r.frame_len = ace_pkg::MIN_FRAME + 11'($urandom_range(0, 40));
      r.hw_type = ace_pkg::HW_ETHER;
      r.proto_type = ace_pkg::PROTO_IPV4;
      r.hw_len = ace_pkg::HW_LEN_ETHER;
      r.proto_len = ace_pkg::PROTO_LEN_IPV4;
      r.arp_op = op;
      r.sender_ha = sha;
      r.sender_pa = spa;
      r.target_pa = tpa;
      r.query_pa = $urandom;
      clk_now = clk_now + $urandom_range(0, 3);
      r.time_now = clk_now;
      return r;
   endfunction

   function automatic ace_pkg::req_type query(logic [31:0] pa);
      ace_pkg::req_type r;
      r = '0;
      r.opcode = ace_pkg::OPC_QUERY;
      r.frame_len = 11'($urandom);
      r.sender_ha = 48'({$urandom, $urandom});
      r.sender_pa = $urandom;
      r.query_pa = pa;
      clk_now = clk_now + $urandom_range(0, 3);
      r.time_now = clk_now;
      return r;
   endfunction

   function automatic logic [31:0] pick_addr();
      return ($urandom_range(0, 3) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
   endfunction

   task automatic test_directed();
      ace_pkg::req_type r;
      write_csr(ace_pkg::CSR_LOCAL_IP, 48'h0000_0A00_0001);
      write_csr(ace_pkg::CSR_LOCAL_MAC, 48'h0200_0000_0001);
      r = good_frame(ace_pkg::ARP_REQ_OP, '1, 32'h0A00_0002, 32'h0A00_0001);
      r.frame_len = ace_pkg::MIN_FRAME - 1;
      send_request(r);
      r.frame_len = '0;
      send_request(r);
      r.frame_len = '1;
      r.hw_type = 16'h0002;
      send_request(r);
      r.hw_type = ace_pkg::HW_ETHER; r.hw_len = 8'hFF;
      send_request(r);
      r.hw_len = ace_pkg::HW_LEN_ETHER; r.proto_type = 16'hFFFF;
      send_request(r);
      r.proto_type = ace_pkg::PROTO_IPV4; r.proto_len = 8'd0;
      send_request(r);
      send_request(query(32'h0A00_0002));
      send_request(query(32'h0A00_0002));
      send_request(good_frame(ace_pkg::ARP_REQ_OP, '1, 32'h0A00_0002, 32'h0A00_0001));
      send_request(query(32'h0A00_0002));
      send_request(good_frame(ace_pkg::ARP_REP_OP, 48'h0, 32'hFFFF_FFFF, 32'h0A00_0001));
      send_request(good_frame(16'hFFFF, 48'h1, 32'h0, 32'h0A00_0001));
      send_request(good_frame(ace_pkg::ARP_REQ_OP, 48'h5, 32'h0A00_0009, 32'h0A00_0077));
      send_request(query(32'hFFFF_FFFF));
      send_request(query(32'h0));
      wait_idle();
      write_csr(ace_pkg::CSR_LINK_ETHER, 48'h0);
      send_request(query(32'h0A00_0002));
      send_request(good_frame(ace_pkg::ARP_REQ_OP, 48'h7, 32'h0A00_0002, 32'h0A00_0001));
      wait_idle();
      write_csr(ace_pkg::CSR_LINK_ETHER, 48'h1);
      write_csr(ace_pkg::CSR_IFACE, 48'h0);
      send_request(query(32'h0A00_0002));
      send_request(good_frame(ace_pkg::ARP_REQ_OP, 48'h8, 32'h0A00_0002, 32'h0A00_0001));
      send_request(good_frame(ace_pkg::ARP_REQ_OP, 48'h9, 32'h0A00_0033, 32'h0A00_0001));
      wait_idle();
      write_csr(ace_pkg::CSR_IFACE, 48'h1);
   endtask

   // well-formed traffic over a small address pool, with noise frames mixed in
   task automatic test_random(int count);
      ace_pkg::req_type r;
      int      k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (k < 40) r = query(pick_addr());
         else if (k < 85)
            r = good_frame($urandom_range(0, 1) ? ace_pkg::ARP_REQ_OP
                                                : 16'($urandom_range(0, 3)),
                           48'({$urandom, $urandom}), pick_addr(),
                           $urandom_range(0, 3) ? my_ip : pick_addr());
         else begin
            r = ace_pkg::req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom}));
            r.time_now = clk_now;
            if ($urandom_range(0, 1)) r.hw_type = ace_pkg::HW_ETHER;
            if ($urandom_range(0, 1)) r.proto_type = ace_pkg::PROTO_IPV4;
         end
         send_request(r);
      end
   endtask

   task automatic test_settings();
      test_random(300);
      wait_idle();
      write_csr(ace_pkg::CSR_LOCAL_IP, 48'h0000_FFFF_FFFF);
      write_csr(ace_pkg::CSR_LOCAL_MAC, 48'hFFFF_FFFF_FFFF);
      test_random(250);
      wait_idle();
      write_csr(ace_pkg::CSR_LOCAL_IP, 48'h0);
      write_csr(ace_pkg::CSR_LOCAL_MAC, 48'h0);
      write_csr(ace_pkg::CSR_IFACE, 48'h0);
      test_random(60);
      wait_idle();
      write_csr(ace_pkg::CSR_IFACE, 48'h1);
      write_csr(ace_pkg::CSR_LOCAL_IP, {16'h0, $urandom});
      write_csr(ace_pkg::CSR_LOCAL_MAC, 48'({$urandom, $urandom}));
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      test_random(40);
      wait_idle();
      test_random(480);
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_idle = $urandom_range(0, 4);
         else if (rsp_idle > 0) rsp_idle = rsp_idle - 1;
         rsp_ready <= (rsp_idle == 0);
      end
   end

   always @(posedge clock) begin
      ace_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_data.status); errors++;
            end
            if (rsp_data.send_frame !== exp_rsp.send_frame) begin
               $error("send_frame exp %0d got %0d", exp_rsp.send_frame,
                      rsp_data.send_frame); errors++;
            end
            if (rsp_data.send_op !== exp_rsp.send_op) begin
               $error("send_op exp %0d got %0d", exp_rsp.send_op, rsp_data.send_op);
               errors++;
            end
            if (rsp_data.send_tha !== exp_rsp.send_tha) begin
               $error("send_tha exp %h got %h", exp_rsp.send_tha, rsp_data.send_tha);
               errors++;
            end
            if (rsp_data.send_tpa !== exp_rsp.send_tpa) begin
               $error("send_tpa exp %h got %h", exp_rsp.send_tpa, rsp_data.send_tpa);
               errors++;
            end
            if (rsp_data.send_broadcast !== exp_rsp.send_broadcast) begin
               $error("send_broadcast exp %0d got %0d", exp_rsp.send_broadcast,
                      rsp_data.send_broadcast); errors++;
            end
            if (rsp_data.resolved_ha !== exp_rsp.resolved_ha) begin
               $error("resolved_ha exp %h got %h", exp_rsp.resolved_ha,
                      rsp_data.resolved_ha); errors++;
            end
         end
      end
   end

   initial begin
      my_ip = '0; my_mac = '0; link_ether = 1'b1; iface_up = 1'b1;
      for (int i = 0; i < NENT; i++) begin
         ent_state[i] = ace_pkg::ENT_FREE; ent_pa[i] = '0; ent_ha[i] = '0;
         ent_stamp[i] = '0;
      end
      for (int i = 0; i < 8; i++) addr_pool[i] = 32'h0A00_0000 + 32'($urandom_range(1, 60));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      test_backpressure();
      wait_idle();
      if (errors == 0)
         $display("arp_cache_engine: match");
      else
         $display("arp_cache_engine: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("arp_cache_engine: mismatch");
      $finish;
   end

endmodule

// ===== arp_cache_engine.f =====
rtl/ace_pkg.sv
rtl/ace_ram.sv
rtl/ace_ctrl.sv
rtl/ace_datapath.sv
rtl/arp_cache_engine.sv
sim/arp_cache_engine_tb.sv
